>>> design/sdh_pkg.sv
// Package for the sample-tagged dial history: constants, payload types, FSM and control types.
package sdh_pkg;

	localparam int HISTORY_DEPTH = 24;
	localparam int POS_W         = 48;
	localparam int HZ_W          = 32;
	localparam int OFS_W         = 20;
	localparam int PAIR_W        = 12;
	localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

	localparam logic [OFS_W-1:0] OFFSET_RESET = OFS_W'(15360);

	localparam logic [1:0] REQ_DIAL    = 2'd0;
	localparam logic [1:0] REQ_WRITTEN = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [HZ_W-1:0]   new_dial_hz;
		logic [PAIR_W-1:0] pair_count;
	} in_item_t;

	typedef struct packed {
		logic [HZ_W-1:0] dial_at_read_hz;
		logic            from_history;
	} out_item_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [HZ_W-1:0]  hz;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic scan;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_sts_t;

	function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		logic [POS_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
	endfunction

endpackage

>>> design/sdh_ctrl.sv
// Controller FSM: sequences capture, state update, history scan and result load.
module sdh_ctrl import sdh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FINISH: begin
				cmd.load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> design/sdh_datapath.sv
// Datapath: counters, dial history memory, newest-first scan and output register.
module sdh_datapath import sdh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [OFS_W-1:0] cfg_wdata,
	input  in_item_t         in_data,
	input  logic             out_ready,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output logic             out_valid,
	output out_item_t        out_data
);

	entry_t           hist_mem [HISTORY_DEPTH];

	in_item_t         req_q;
	logic [OFS_W-1:0] offset_q;
	logic [HZ_W-1:0]  cur_dial_q;
	logic [POS_W-1:0] written_q;
	logic [POS_W-1:0] read_q;
	logic [IDX_W-1:0] next_slot_q;
	logic [FILL_W-1:0] filled_q;

	logic [IDX_W-1:0]  rd_idx_q;
	logic [FILL_W-1:0] scan_left_q;
	entry_t            rd_q;
	logic              rd_vld_q;

	logic              found_q;
	logic [POS_W-1:0]  best_pos_q;
	logic [HZ_W-1:0]   best_hz_q;

	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              dial_we;
	logic [IDX_W-1:0]  slot_next;
	logic [IDX_W-1:0]  slot_prev;
	logic [IDX_W-1:0]  rd_idx_prev;
	logic [FILL_W-1:0] filled_new;
	logic              rd_fire;
	logic              better;

	assign dial_we   = cmd.apply && (req_q.req_type == REQ_DIAL) &&
		(req_q.new_dial_hz != cur_dial_q);
	assign slot_next = (next_slot_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : next_slot_q + 1'b1;
	assign slot_prev = (next_slot_q == '0) ? IDX_W'(HISTORY_DEPTH - 1) : next_slot_q - 1'b1;
	assign rd_idx_prev = (rd_idx_q == '0) ? IDX_W'(HISTORY_DEPTH - 1) : rd_idx_q - 1'b1;
	assign filled_new = (dial_we && (filled_q < FILL_W'(HISTORY_DEPTH))) ?
		filled_q + 1'b1 : filled_q;
	assign rd_fire   = cmd.scan && (scan_left_q != '0);
	assign better    = rd_vld_q && (rd_q.pos <= read_q) &&
		(!found_q || (rd_q.pos > best_pos_q));

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= OFFSET_RESET;
			cur_dial_q  <= '0;
			written_q   <= '0;
			read_q      <= '0;
			next_slot_q <= '0;
			filled_q    <= '0;
			scan_left_q <= '0;
			rd_vld_q    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) offset_q <= cfg_wdata;
			if (cmd.apply) begin
				case (req_q.req_type)
					REQ_DIAL: begin
						if (dial_we) begin
							cur_dial_q  <= req_q.new_dial_hz;
							next_slot_q <= slot_next;
							filled_q    <= filled_new;
						end
					end
					REQ_WRITTEN: written_q <= sat_add(written_q, POS_W'(req_q.pair_count));
					REQ_READ:    read_q    <= sat_add(read_q, POS_W'(req_q.pair_count));
					default: ;
				endcase
				scan_left_q <= filled_new;
				found_q     <= 1'b0;
			end else begin
				if (rd_fire) scan_left_q <= scan_left_q - 1'b1;
				if (better)  found_q     <= 1'b1;
			end
			rd_vld_q <= rd_fire;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= in_data;
		if (cmd.apply) begin
			rd_idx_q <= dial_we ? next_slot_q : slot_prev;
		end else if (rd_fire) begin
			rd_idx_q <= rd_idx_prev;
		end
		if (better) begin
			best_pos_q <= rd_q.pos;
			best_hz_q  <= rd_q.hz;
		end
		if (cmd.load) begin
			out_data_q.dial_at_read_hz <= found_q ? best_hz_q : cur_dial_q;
			out_data_q.from_history    <= found_q;
		end
	end

	// History memory
	always_ff @(posedge clk) begin
		if (dial_we) begin
			hist_mem[next_slot_q] <= '{pos: sat_add(written_q, POS_W'(offset_q)),
				hz: req_q.new_dial_hz};
		end
		if (rd_fire) rd_q <= hist_mem[rd_idx_q];
	end

	assign sts.scan_done = (scan_left_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_W'(HISTORY_DEPTH))
		else $error("history fill count above depth");
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_slot_q < IDX_W'(HISTORY_DEPTH))
		else $error("next slot out of range");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_left_q <= filled_q)
		else $error("scan count exceeds filled entries");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load))
		else $error("result shown without a load");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before taken");
`endif

endmodule

>>> design/sample_tagged_dial_history_core.sv
// Top level: sample-tagged dial history with controller and datapath.
// Per request: capture in IDLE, state update in APPLY, scan in SCAN, result load in FINISH.
// The scan reads the filled entries (0..24) newest first, one entry per cycle, through the
// single read port of the history memory; a new request is taken only after the result load.
// The output register lets a new request enter while a result waits to be taken.
// Reset (arst_n low, asynchronous): counters, dial, ring pointers cleared; offset to 15360.
module sample_tagged_dial_history_core import sdh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [OFS_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	sdh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
